[rtl/uks_pkg.sv]
// uks_pkg: shared sizes, command and status codes, and item types for the
// unique key stack. No dependencies; imported by uks_ctrl and unique_key_stack.
package uks_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int KEY_W       = 32;
    localparam int ENTRY_W     = 2 * KEY_W;

    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_PEEK = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_UNDER = 2'd2;
    localparam logic [1:0] ST_OVER  = 2'd3;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] entry_key;
        logic signed [31:0] entry_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] top_key;
        logic signed [31:0] top_value;
        logic [4:0]         entry_count;
        logic               is_empty;
    } t_out_item;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_res_evt;

endpackage

[rtl/uks_ram.sv]
// uks_ram: generic simple dual-port ram, one write and one registered read.
// No dependencies.
module uks_ram #(
    parameter int  WIDTH = 64,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/uks_ctrl.sv]
// uks_ctrl: sequencer with the single key comparator; scans the entry ram
// for duplicates, pushes, pops and peeks. Depends on uks_pkg and uks_ram.
module uks_ctrl import uks_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in_item,
    input  logic     i_out_free,
    output logic     o_busy,
    output t_res_evt o_res
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_RDTOP  = 5'b00100,
        S_TOPDAT = 5'b01000,
        S_FIN    = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_depth, n_depth;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_pend, n_pend;
    logic [1:0]        r_cmd, n_cmd;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [KEY_W-1:0]  r_val, n_val;
    logic [1:0]        r_status, n_status;
    logic [KEY_W-1:0]  r_tk, n_tk;
    logic [KEY_W-1:0]  r_tv, n_tv;

    logic               ram_we;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [KEY_W-1:0]   rd_key;
    logic [KEY_W-1:0]   rd_val;
    logic               hit;
    logic               issue;
    logic [CNT_W+4:0]   count_ext;

    uks_ram #(.WIDTH(ENTRY_W), .DEPTH(STACK_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_depth[ADDR_W-1:0]),
        .i_wdata ({r_key, r_val}),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign rd_key = ram_rdata[ENTRY_W-1:KEY_W];
    assign rd_val = ram_rdata[KEY_W-1:0];
    assign hit    = r_pend && (rd_key == r_key);
    assign issue  = r_idx < r_depth;

    always_comb begin
        n_state  = r_state;
        n_depth  = r_depth;
        n_idx    = r_idx;
        n_pend   = r_pend;
        n_cmd    = r_cmd;
        n_key    = r_key;
        n_val    = r_val;
        n_status = r_status;
        n_tk     = r_tk;
        n_tv     = r_tv;
        ram_we   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd    = i_in_item.command;
                    n_key    = i_in_item.entry_key;
                    n_val    = i_in_item.entry_value;
                    n_tk     = '0;
                    n_tv     = '0;
                    n_status = ST_OK;
                    unique case (i_in_item.command)
                        CMD_PUSH: begin
                            n_idx   = '0;
                            n_pend  = 1'b0;
                            n_state = S_SCAN;
                        end
                        CMD_POP, CMD_PEEK: begin
                            if (r_depth == '0) begin
                                n_status = ST_UNDER;
                                n_state  = S_FIN;
                            end else begin
                                n_idx   = r_depth - 1'b1;
                                n_state = S_RDTOP;
                            end
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                priority if (hit) begin
                    n_pend   = 1'b0;
                    n_status = ST_DUP;
                    n_state  = S_FIN;
                end else if (issue) begin
                    n_idx  = r_idx + 1'b1;
                    n_pend = 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_FIN;
                    if (r_depth == CNT_W'(STACK_DEPTH)) begin
                        n_status = ST_OVER;
                    end else begin
                        ram_we  = 1'b1;
                        n_depth = r_depth + 1'b1;
                    end
                end
            end
            S_RDTOP: begin
                n_state = S_TOPDAT;
            end
            S_TOPDAT: begin
                n_tk = rd_key;
                n_tv = rd_val;
                if (r_cmd == CMD_POP) begin
                    n_depth = r_depth - 1'b1;
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_depth <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_cmd    <= n_cmd;
        r_key    <= n_key;
        r_val    <= n_val;
        r_status <= n_status;
        r_tk     <= n_tk;
        r_tv     <= n_tv;
    end

    assign count_ext = {5'b0, r_depth};

    assign o_busy                  = (r_state != S_IDLE);
    assign o_res.valid             = (r_state == S_FIN);
    assign o_res.item.status       = r_status;
    assign o_res.item.top_key      = r_tk;
    assign o_res.item.top_value    = r_tv;
    assign o_res.item.entry_count  = count_ext[4:0];
    assign o_res.item.is_empty     = (r_depth == '0);

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= CNT_W'(STACK_DEPTH))
        else $error("stack depth beyond limit");

    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TOPDAT && r_cmd == CMD_POP)
        |=> r_depth == CNT_W'($past(r_depth) - 1'b1))
        else $error("pop did not remove one entry");

    a_write_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_SCAN && !hit && r_depth < CNT_W'(STACK_DEPTH)))
        else $error("entry written outside a clean push");

    a_scan_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= r_depth))
        else $error("scan index past top of stack");

endmodule

[rtl/unique_key_stack.sv]
// unique_key_stack: lifo of key/value pairs with a duplicate key check.
// push: the ram scan compares one entry a cycle
// pop/peek: top read through the registered ram; underflow or unused code skip the read
// one item in flight; next item accepted the cycle after the result is handed to
// the output register
// synchronous active-low reset empties the stack; ram contents are not cleared
module unique_key_stack import uks_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic      out_free;
    logic      busy;
    t_res_evt  res;
    logic      r_out_vld;
    t_out_item r_out_item;

    assign out_free = !r_out_vld || !i_out_stall;

    uks_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .i_out_free (out_free),
        .o_busy     (busy),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res.valid && out_free) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid && out_free) begin
            r_out_item <= res.item;
        end
    end

    assign o_in_stall  = busy;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

endmodule
